>>> rtl/rgbrle_pkg.sv
// ============================================================================
// rgbrle_pkg
// Shared types and constants for the RGB565 run-length encoder.
// ============================================================================
package rgbrle_pkg;

   localparam int unsigned PIXEL_WIDTH = 16;
   localparam int unsigned COUNT_WIDTH = 8;
   localparam int unsigned BYTE_WIDTH  = 8;
   localparam int unsigned TOTAL_WIDTH = 24;

   // Longest run one count byte can carry.
   localparam logic [COUNT_WIDTH-1:0] MAX_RUN = 8'd255;
   // Bytes per encoded run, one bit wider than the byte counter.
   localparam logic [TOTAL_WIDTH:0]   BYTES_PER_RUN = 25'd3;
   localparam logic [TOTAL_WIDTH:0]   BYTES_TWO_RUNS = 25'd6;
   localparam logic [TOTAL_WIDTH-1:0] MAX_OUT_RESET = 24'hFFFFFF;

   // One unit of work for the back end: a whole run, or an abort marker.
   typedef struct packed {
      logic                   fail;
      logic [COUNT_WIDTH-1:0] count;
      logic [PIXEL_WIDTH-1:0] color;
      logic                   last;
      logic [TOTAL_WIDTH-1:0] total;
   } cmd_type;

   // Byte phase of the serializer.
   typedef enum logic [2:0] {
      PH_COUNT = 3'b001,
      PH_LOW   = 3'b010,
      PH_HIGH  = 3'b100
   } phase_type;

endpackage

>>> rtl/rgbrle_front.sv
// ============================================================================
// rgbrle_front
// Run tracking, limit check and command issue; up to two commands per pixel.
// ============================================================================
module rgbrle_front import rgbrle_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [TOTAL_WIDTH-1:0] max_out_bytes,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PIXEL_WIDTH-1:0] req_pixel_color,
   input  logic                   req_last_pixel,
   output logic                   push_valid,
   input  logic                   push_ready,
   output cmd_type                push_cmd
);

   logic [PIXEL_WIDTH-1:0] run_color_ff, run_color_in;
   logic [COUNT_WIDTH-1:0] run_len_ff, run_len_in;
   logic [TOTAL_WIDTH-1:0] bytes_ff, bytes_in;
   logic                   drop_ff, drop_in;
   logic                   pend_valid_ff, pend_valid_in;
   cmd_type                pend_cmd_ff, pend_cmd_in;

   logic                   accept;
   logic                   extend, close, fail_a, fail_b;
   logic [TOTAL_WIDTH:0]   limit_w, bytes3, bytes6, mid3;
   logic [COUNT_WIDTH-1:0] new_len;
   logic [PIXEL_WIDTH-1:0] new_color;
   logic                   cmd_a_valid, cmd_b_valid;
   cmd_type                cmd_a, cmd_b;

   assign req_ready = !pend_valid_ff && push_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      extend  = (run_len_ff != '0) && (req_pixel_color == run_color_ff)
                && (run_len_ff < MAX_RUN);
      close   = !extend && (run_len_ff != '0);
      limit_w = {1'b0, max_out_bytes};
      bytes3  = {1'b0, bytes_ff} + BYTES_PER_RUN;
      bytes6  = {1'b0, bytes_ff} + BYTES_TWO_RUNS;
      fail_a  = close && (bytes3 > limit_w);
      mid3    = close ? bytes6 : bytes3;
      fail_b  = mid3 > limit_w;

      new_len   = extend ? run_len_ff + 8'd1 : 8'd1;
      new_color = extend ? run_color_ff : req_pixel_color;

      // closing the open run
      cmd_a_valid = !drop_ff && close;
      cmd_a       = '0;
      cmd_a.fail  = fail_a;
      if (!fail_a) begin
         cmd_a.count = run_len_ff;
         cmd_a.color = run_color_ff;
      end

      // flushing the run at end of frame
      cmd_b_valid = !drop_ff && !fail_a && req_last_pixel;
      cmd_b       = '0;
      cmd_b.fail  = fail_b;
      if (!fail_b) begin
         cmd_b.count = new_len;
         cmd_b.color = new_color;
         cmd_b.last  = 1'b1;
         cmd_b.total = mid3[TOTAL_WIDTH-1:0];
      end
   end

   assign push_valid = pend_valid_ff || (accept && (cmd_a_valid || cmd_b_valid));
   assign push_cmd   = pend_valid_ff ? pend_cmd_ff : (cmd_a_valid ? cmd_a : cmd_b);

   always_comb begin
      run_color_in  = run_color_ff;
      run_len_in    = run_len_ff;
      bytes_in      = bytes_ff;
      drop_in       = drop_ff;
      pend_valid_in = pend_valid_ff && !push_ready;
      pend_cmd_in   = pend_cmd_ff;
      if (accept) begin
         if (cmd_a_valid && cmd_b_valid) begin
            pend_valid_in = 1'b1;
            pend_cmd_in   = cmd_b;
         end
         if (drop_ff) begin
            drop_in = !req_last_pixel;
         end else if (fail_a || req_last_pixel) begin
            run_color_in = '0;
            run_len_in   = '0;
            bytes_in     = '0;
            drop_in      = fail_a && !req_last_pixel;
         end else begin
            run_color_in = new_color;
            run_len_in   = new_len;
            bytes_in     = close ? bytes3[TOTAL_WIDTH-1:0] : bytes_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_color_ff  <= '0;
         run_len_ff    <= '0;
         bytes_ff      <= '0;
         drop_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         run_color_ff  <= run_color_in;
         run_len_ff    <= run_len_in;
         bytes_ff      <= bytes_in;
         drop_ff       <= drop_in;
         pend_valid_ff <= pend_valid_in;
      end
      pend_cmd_ff <= pend_cmd_in;
   end

endmodule

>>> rtl/rgbrle_queue.sv
// ============================================================================
// rgbrle_queue
// Two-entry command FIFO between front and back.
// ============================================================================
module rgbrle_queue import rgbrle_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/rgbrle_back.sv
// ============================================================================
// rgbrle_back
// Serializes runs as count, color low, color high beats; abort is one beat.
// ============================================================================
module rgbrle_back import rgbrle_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  cmd_type                pop_cmd,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [BYTE_WIDTH-1:0]  rsp_out_byte,
   output logic                   rsp_last,
   output logic                   rsp_failed,
   output logic [TOTAL_WIDTH-1:0] rsp_total_bytes
);

   cmd_type   cmd_ff, cmd_in;
   logic      active_ff, active_in;
   phase_type phase_ff, phase_in;
   logic      final_beat;

   // an abort marker is a single beat
   assign final_beat = cmd_ff.fail || (phase_ff == PH_HIGH);
   assign pop_ready  = !active_ff || (rsp_ready && final_beat);
   assign rsp_valid  = active_ff;

   always_comb begin
      rsp_out_byte    = '0;
      rsp_last        = cmd_ff.fail;
      rsp_failed      = cmd_ff.fail;
      rsp_total_bytes = '0;
      if (!cmd_ff.fail) begin
         case (phase_ff)
            PH_COUNT: rsp_out_byte = cmd_ff.count;
            PH_LOW:   rsp_out_byte = cmd_ff.color[BYTE_WIDTH-1:0];
            PH_HIGH: begin
               rsp_out_byte    = cmd_ff.color[PIXEL_WIDTH-1:BYTE_WIDTH];
               rsp_last        = cmd_ff.last;
               rsp_total_bytes = cmd_ff.total;
            end
            default: rsp_out_byte = '0;
         endcase
      end
   end

   always_comb begin
      cmd_in    = cmd_ff;
      active_in = active_ff;
      phase_in  = phase_ff;
      if (pop_valid && pop_ready) begin
         cmd_in    = pop_cmd;
         active_in = 1'b1;
         phase_in  = PH_COUNT;
      end else if (active_ff && rsp_ready) begin
         if (final_beat) begin
            active_in = 1'b0;
         end else begin
            case (phase_ff)
               PH_COUNT: phase_in = PH_LOW;
               PH_LOW:   phase_in = PH_HIGH;
               default:  phase_in = PH_COUNT;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         phase_ff  <= PH_COUNT;
      end else begin
         active_ff <= active_in;
         phase_ff  <= phase_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

>>> rtl/rgb565_run_length_encoder_top.sv
// ============================================================================
// rgb565_run_length_encoder_top
// Path: a run's command goes through a queue entry, then the back-end command register.
// Throughput: 1 pixel/cycle on extends unless stalled, 1 beat/cycle on rsp_ready.
// Reset: synchronous, active high; empties queue, clears run state, limit 0xFFFFFF.
// ============================================================================
module rgb565_run_length_encoder_top import rgbrle_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // limit register write
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [TOTAL_WIDTH-1:0] csr_max_out_bytes,
   // pixel stream
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PIXEL_WIDTH-1:0] req_pixel_color,
   input  logic                   req_last_pixel,
   // encoded byte stream
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [BYTE_WIDTH-1:0]  rsp_out_byte,
   output logic                   rsp_last,
   output logic                   rsp_failed,
   output logic [TOTAL_WIDTH-1:0] rsp_total_bytes
);

   // Frame size limit; writes are always taken.
   logic [TOTAL_WIDTH-1:0] max_out_ff, max_out_in;

   // Front -> queue -> back command path.
   logic    push_valid, push_ready;
   cmd_type push_cmd;
   logic    pop_valid, pop_ready;
   cmd_type pop_cmd;

   assign csr_ready  = 1'b1;
   assign max_out_in = (csr_valid && csr_ready) ? csr_max_out_bytes : max_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_out_ff <= MAX_OUT_RESET;
      end else begin
         max_out_ff <= max_out_in;
      end
   end

   // Front end: tracks the open run and byte count, checks the limit and
   // issues whole-run or abort commands. A pixel that both closes a run and
   // ends the frame issues two commands; the second waits in a holding slot.
   rgbrle_front u_front (
      .clock           (clock),
      .reset           (reset),
      .max_out_bytes   (max_out_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_color (req_pixel_color),
      .req_last_pixel  (req_last_pixel),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_cmd        (push_cmd)
   );

   // Two-entry queue decouples pixel intake from byte output.
   rgbrle_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // Back end: turns each command into three beats, or one beat on abort.
   // The command register doubles as the output register.
   rgbrle_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_cmd         (pop_cmd),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last        (rsp_last),
      .rsp_failed      (rsp_failed),
      .rsp_total_bytes (rsp_total_bytes)
   );

endmodule
